### rtl/lvs_pkg.sv
package lvs_pkg;

    localparam int SET_COUNT_DEF   = 64;
    localparam int WAYS_DEF        = 8;
    localparam int STAMP_WIDTH_DEF = 64;

    localparam int OPER_W  = 2;
    localparam int SET_IN_W = 6;
    localparam int WAY_IN_W = 3;
    localparam int MASK_W  = 8;

    localparam logic [OPER_W-1:0] OP_SELECT = 2'd0;
    localparam logic [OPER_W-1:0] OP_ACCESS = 2'd1;
    localparam logic [OPER_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic acc_wr;
        logic cnt_clr;
        logic sweep_wr;
        logic scan_init;
        logic scan_step;
        logic finish;
    } lvs_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic sweep_last;
    } lvs_sts_t;

endpackage

### rtl/lvs_ctrl.sv
module lvs_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lvs_pkg::OPER_W-1:0]    operation,
    input  lvs_pkg::lvs_sts_t             sts,
    output lvs_pkg::lvs_cmd_t             cmd,
    output logic                          busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (operation)
                        lvs_pkg::OP_SELECT:
                        begin
                            cmd.rd_en  = 1'b1;
                            state_next = ST_LOAD;
                        end
                        lvs_pkg::OP_ACCESS:
                        begin
                            cmd.acc_wr = 1'b1;
                        end
                        lvs_pkg::OP_CLEAR:
                        begin
                            cmd.cnt_clr = 1'b1;
                            state_next  = ST_SWEEP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_LOAD:
            begin
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

### rtl/lvs_datapath.sv
module lvs_datapath
#(
    parameter int SET_COUNT   = lvs_pkg::SET_COUNT_DEF,
    parameter int WAYS        = lvs_pkg::WAYS_DEF,
    parameter int STAMP_WIDTH = lvs_pkg::STAMP_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  lvs_pkg::lvs_cmd_t               cmd,
    output lvs_pkg::lvs_sts_t               sts,
    input  logic [lvs_pkg::SET_IN_W-1:0]    set_id,
    input  logic [lvs_pkg::WAY_IN_W-1:0]    way,
    input  logic [lvs_pkg::MASK_W-1:0]      eligible_mask,
    output logic [lvs_pkg::WAY_IN_W-1:0]    victim_way,
    output logic                            done
);

    localparam int SET_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
    localparam int WAY_W = $clog2(WAYS);
    localparam int ROW_W = WAYS * STAMP_WIDTH;

    logic [ROW_W-1:0]                  mem [SET_COUNT];
    logic [ROW_W-1:0]                  row_reg;
    logic [STAMP_WIDTH-1:0]            counter_reg;
    logic [STAMP_WIDTH-1:0]            counter_inc;
    logic [SET_W-1:0]                  sweep_idx_reg;
    logic [WAY_W-1:0]                  scan_idx_reg;
    logic [STAMP_WIDTH-1:0]            best_stamp_reg;
    logic [lvs_pkg::WAY_IN_W-1:0]      best_way_reg;
    logic [lvs_pkg::MASK_W-1:0]        mask_reg;
    logic                              in_range_reg;
    logic                              done_reg;

    logic [31:0]                       set_ext;
    logic [SET_W-1:0]                  set_addr;
    logic                              set_ok;
    logic                              way_ok;
    logic [WAY_W-1:0]                  way_addr;
    logic                              acc_ok;
    logic [STAMP_WIDTH-1:0]            cand_stamp;
    logic [lvs_pkg::WAY_IN_W-1:0]      scan_idx_low;
    logic                              cand_eligible;
    logic                              cand_wins;

    assign set_ext     = 32'(set_id);
    assign set_addr    = set_ext[SET_W-1:0];
    assign set_ok      = (set_ext < 32'(SET_COUNT));
    assign way_ok      = (32'(way) < 32'(WAYS));
    assign way_addr    = WAY_W'(way);
    assign acc_ok      = cmd.acc_wr && set_ok && way_ok;
    assign counter_inc = counter_reg + STAMP_WIDTH'(1);

    assign cand_stamp    = row_reg[scan_idx_reg*STAMP_WIDTH +: STAMP_WIDTH];
    assign scan_idx_low  = lvs_pkg::WAY_IN_W'(scan_idx_reg);
    assign cand_eligible = (32'(scan_idx_reg) < 32'(lvs_pkg::MASK_W))
                           && mask_reg[scan_idx_low];
    assign cand_wins     = in_range_reg && cand_eligible && (cand_stamp < best_stamp_reg);

    assign sts.scan_last  = (32'(scan_idx_reg) == 32'(WAYS - 1));
    assign sts.sweep_last = (32'(sweep_idx_reg) == 32'(SET_COUNT - 1));

    // stamp memory: sweep clears a row, access writes one way
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_wr)
        begin
            mem[sweep_idx_reg] <= '0;
        end
        else if (acc_ok)
        begin
            mem[set_addr][way_addr*STAMP_WIDTH +: STAMP_WIDTH] <= counter_inc;
        end
        if (cmd.rd_en)
        begin
            row_reg <= mem[set_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            mask_reg <= eligible_mask;
        end
        if (cmd.scan_init)
        begin
            best_stamp_reg <= row_reg[STAMP_WIDTH-1:0];
        end
        else if (cmd.scan_step && cand_wins)
        begin
            best_stamp_reg <= cand_stamp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg   <= '0;
            sweep_idx_reg <= '0;
            scan_idx_reg  <= '0;
            best_way_reg  <= '0;
            in_range_reg  <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.cnt_clr)
            begin
                counter_reg <= '0;
            end
            else if (acc_ok)
            begin
                counter_reg <= counter_inc;
            end
            if (cmd.sweep_wr)
            begin
                sweep_idx_reg <= sts.sweep_last ? '0 : sweep_idx_reg + SET_W'(1);
            end
            if (cmd.rd_en)
            begin
                in_range_reg <= set_ok;
            end
            if (cmd.scan_init)
            begin
                scan_idx_reg <= WAY_W'(1);
                best_way_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                scan_idx_reg <= scan_idx_reg + WAY_W'(1);
                if (cand_wins)
                begin
                    best_way_reg <= scan_idx_low;
                end
            end
        end
    end

    assign victim_way = best_way_reg;
    assign done       = done_reg;

endmodule

### rtl/lru_victim_select.sv
// true lru victim selection by access stamps for a set-associative cache
//
// command channel: a transaction is taken on a rising edge with start high and
// busy low; operation, set_id, way and eligible_mask are sampled there.
//   select: reads the set's stamp row, then a single comparator walks the ways,
//           one way per cycle; victim_way is shown with done for exactly one
//           cycle once the last way is compared; busy drops in that same cycle
//   access: writes counter + 1 into one way's stamp at the accepting edge;
//           busy never rises, one transaction per cycle
//   clear:  zeroes the counter, then sweeps the stamp memory one row per
//           cycle; busy until the last row is cleared
// a select is bounded by the shared way comparator, a clear by the single
// memory write port
// reset: asynchronous, active low; afterwards the block runs the same clearing
// sweep (busy high throughout) before it takes a transaction
// results cannot be held off: done is a one-cycle strobe
module lru_victim_select
#(
    parameter int SET_COUNT   = lvs_pkg::SET_COUNT_DEF,
    parameter int WAYS        = lvs_pkg::WAYS_DEF,
    parameter int STAMP_WIDTH = lvs_pkg::STAMP_WIDTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [lvs_pkg::OPER_W-1:0]      operation,
    input  logic [lvs_pkg::SET_IN_W-1:0]    set_id,
    input  logic [lvs_pkg::WAY_IN_W-1:0]    way,
    input  logic [lvs_pkg::MASK_W-1:0]      eligible_mask,
    output logic                            done,
    output logic [lvs_pkg::WAY_IN_W-1:0]    victim_way
);

    lvs_pkg::lvs_cmd_t cmd;
    lvs_pkg::lvs_sts_t sts;

    lvs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    lvs_datapath
    #(
        .SET_COUNT   (SET_COUNT),
        .WAYS        (WAYS),
        .STAMP_WIDTH (STAMP_WIDTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .set_id        (set_id),
        .way           (way),
        .eligible_mask (eligible_mask),
        .victim_way    (victim_way),
        .done          (done)
    );

endmodule

### rtl/lvs_checker.sv
module lvs_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            busy,
    input  logic [lvs_pkg::OPER_W-1:0]      operation,
    input  logic                            done
);

    // a result never coincides with a pending transaction
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a preceding select");

    a_select_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == lvs_pkg::OP_SELECT) |=> (busy && !done))
        else $error("select did not hold busy");

    a_access_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == lvs_pkg::OP_ACCESS) |=> (!busy && !done))
        else $error("access produced a result or stalled");

endmodule

bind lru_victim_select lvs_checker u_lvs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .operation (operation),
    .done      (done)
);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import lvs_pkg::*;

    localparam int N_SETS = SET_COUNT_DEF;
    localparam int N_WAYS = WAYS_DEF;
    localparam int STW = STAMP_WIDTH_DEF;
    localparam logic [OPER_W-1:0] OP_SPARE = 2'd3;
    localparam int STALL_LIMIT = 4000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OPER_W-1:0]   operation;
    logic [SET_IN_W-1:0] set_id;
    logic [WAY_IN_W-1:0] way;
    logic [MASK_W-1:0]   eligible_mask;
    logic                done;
    logic [WAY_IN_W-1:0] victim_way;

    logic [STW-1:0]      stamp_mem [N_SETS][N_WAYS];
    logic [STW-1:0]      touch_count;
    logic [WAY_IN_W-1:0] victim_fifo [$];
    logic [WAY_IN_W-1:0] exp_way;
    int                  err_count = 0;
    int                  sent_items = 0;
    int                  stall_cycles = 0;
    bit                  gaps_on = 1'b1;

    lru_victim_select u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .set_id        (set_id),
        .way           (way),
        .eligible_mask (eligible_mask),
        .done          (done),
        .victim_way    (victim_way)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_stamps();
        for (int s = 0; s < N_SETS; s++)
        begin
            for (int w = 0; w < N_WAYS; w++)
            begin
                stamp_mem[s][w] = '0;
            end
        end
        touch_count = '0;
    endfunction

    // way 0 always starts as candidate, strict compare keeps lowest index on ties
    function automatic logic [WAY_IN_W-1:0] oldest_way(input int s,
                                                       input logic [MASK_W-1:0] m);
        logic [WAY_IN_W-1:0] best;
        logic [STW-1:0]      best_stamp;
        best = '0;
        best_stamp = stamp_mem[s][0];
        for (int w = 1; w < N_WAYS && w < MASK_W; w++)
        begin
            if (m[w] && stamp_mem[s][w] < best_stamp)
            begin
                best_stamp = stamp_mem[s][w];
                best = w[WAY_IN_W-1:0];
            end
        end
        return best;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_stamps();
            victim_fifo.delete();
        end
        else
        begin
            if (done)
            begin
                if (victim_fifo.size() == 0)
                begin
                    err_count++;
                    $error("victim_way: expected none, actual %0d", victim_way);
                end
                else
                begin
                    exp_way = victim_fifo.pop_front();
                    if (victim_way !== exp_way)
                    begin
                        err_count++;
                        $error("victim_way: expected %0d, actual %0d", exp_way, victim_way);
                    end
                end
            end
            if (start && !busy)
            begin
                case (operation)
                    OP_SELECT:
                    begin
                        victim_fifo.push_back(oldest_way(int'(set_id), eligible_mask));
                    end
                    OP_ACCESS:
                    begin
                        touch_count = touch_count + STW'(1);
                        stamp_mem[set_id][way] = touch_count;
                    end
                    OP_CLEAR:
                    begin
                        clear_stamps();
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_item(input logic [OPER_W-1:0] op, input int s,
                             input int w, input int m);
        operation <= op;
        set_id <= SET_IN_W'(s);
        way <= WAY_IN_W'(w);
        eligible_mask <= MASK_W'(m);
        start <= 1'b1;
        do @(posedge clk); while (busy !== 1'b0);
        if (op != OP_SPARE)
        begin
            sent_items++;
        end
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic maybe_gap();
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            hold_off($urandom_range(1, 10));
        end
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge clk); while (victim_fifo.size() != 0);
    endtask

    function automatic int pick_set();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 0;
        end
        if (r == 1)
        begin
            return N_SETS - 1;
        end
        if (r < 6)
        begin
            return $urandom_range(0, 3);
        end
        return $urandom_range(0, N_SETS - 1);
    endfunction

    function automatic int pick_mask();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            return 0;
        end
        if (r == 1)
        begin
            return 'hFF;
        end
        if (r < 4)
        begin
            return 1 << $urandom_range(0, MASK_W - 1);
        end
        return $urandom;
    endfunction

    task automatic test_way0_and_ties();
        send_item(OP_SELECT, 0, 0, 'hFF);
        send_item(OP_SELECT, N_SETS - 1, 7, 'h00);
        send_item(OP_ACCESS, 5, 0, 'h00);
        send_item(OP_SELECT, 5, 0, 'hFE);
        send_item(OP_SELECT, 5, 0, 'h00);
        for (int w = 1; w < N_WAYS; w++)
        begin
            send_item(OP_ACCESS, 5, w, 'hFF);
        end
        send_item(OP_SELECT, 5, 7, 'hFF);
        send_item(OP_SELECT, 5, 0, 'hFE);
        send_item(OP_ACCESS, 5, 0, 'h00);
        send_item(OP_SELECT, 5, 0, 'h80);
        send_item(OP_SELECT, 5, 0, 'h01);
        // unused opcode must leave stamps and counter alone
        send_item(OP_SPARE, 5, 1, 'hFF);
        send_item(OP_SELECT, 5, 0, 'hFF);
        send_item(OP_SELECT, N_SETS - 1, 0, 'h55);
    endtask

    task automatic test_clear_restart();
        send_item(OP_ACCESS, N_SETS - 1, 7, 'h00);
        send_item(OP_ACCESS, 0, 0, 'hFF);
        send_item(OP_CLEAR, N_SETS - 1, 7, 'hFF);
        send_item(OP_SELECT, N_SETS - 1, 7, 'hFF);
        send_item(OP_ACCESS, N_SETS - 1, 3, 'h00);
        send_item(OP_SELECT, N_SETS - 1, 0, 'hFF);
        send_item(OP_SELECT, N_SETS - 1, 0, 'hF7);
    endtask

    // touch a set's ways in random order, then pick victims from it
    task automatic test_set_traffic(input int n_items);
        int target;
        int n_touch;
        int n_pick;
        int hot;
        target = sent_items + n_items;
        while (sent_items < target)
        begin
            gaps_on = ($urandom_range(0, 9) < 7);
            hot = pick_set();
            n_touch = $urandom_range(1, 14);
            repeat (n_touch)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_item(OP_ACCESS, $urandom, $urandom, $urandom);
                end
                else
                begin
                    send_item(OP_ACCESS, hot, $urandom, $urandom);
                end
                maybe_gap();
            end
            n_pick = $urandom_range(1, 4);
            repeat (n_pick)
            begin
                send_item(OP_SELECT, hot, $urandom, pick_mask());
                maybe_gap();
            end
            if ($urandom_range(0, 7) == 0)
            begin
                send_item(OP_SPARE, $urandom, $urandom, $urandom);
            end
            if ($urandom_range(0, 39) == 0)
            begin
                send_item(OP_CLEAR, $urandom, $urandom, $urandom);
            end
        end
    endtask

    task automatic test_drain_pause();
        repeat (3)
        begin
            repeat (6)
            begin
                send_item(OP_ACCESS, 2, $urandom, $urandom);
            end
            send_item(OP_SELECT, 2, $urandom, pick_mask());
            send_item(OP_SELECT, 2, $urandom, 'hFF);
            wait_for_results();
        end
    endtask

    task automatic test_back_to_back(input int n_items);
        int r;
        gaps_on = 1'b0;
        repeat (n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 52)
            begin
                send_item(OP_ACCESS, $urandom_range(0, 3), $urandom, $urandom);
            end
            else if (r < 94)
            begin
                send_item(OP_SELECT, $urandom_range(0, 3), $urandom, pick_mask());
            end
            else if (r < 98)
            begin
                send_item(OP_SPARE, $urandom, $urandom, $urandom);
            end
            else
            begin
                send_item(OP_CLEAR, $urandom, $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_SELECT;
        set_id = '0;
        way = '0;
        eligible_mask = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_way0_and_ties();
        test_clear_restart();
        test_set_traffic(1000);
        test_drain_pause();
        test_back_to_back(250);

        wait_for_results();
        repeat (N_SETS + N_WAYS + 4) @(posedge clk);
        if (err_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/lvs_pkg.sv
rtl/lvs_ctrl.sv
rtl/lvs_datapath.sv
rtl/lru_victim_select.sv
rtl/lvs_checker.sv
sim/tb_top.sv
